[rtl/skf_pkg.sv]
// skf_pkg: widths, constants, microcode word and program rom for the scalar kalman filter
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int FracBits = 16;

  localparam int MeasW   = 16;
  localparam int EstW    = 32;
  localparam int CovW    = 32;
  localparam int NoiseW  = 32;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgProcessNoise = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMeasNoise    = CfgIdxW'(1);

  localparam logic [NoiseW-1:0] ProcessNoiseRst = NoiseW'(1180);
  localparam logic [NoiseW-1:0] MeasNoiseRst    = NoiseW'(35521);

  // gain is unsigned q1.f so that it can hold the value 1.0
  localparam int GainW   = FracBits + 1;
  localparam int ScaledW = MeasW + FracBits;
  localparam int DiffW   = ((ScaledW > EstW) ? ScaledW : EstW) + 1;
  localparam int ProdW   = DiffW + GainW;
  localparam int DeltaW  = ProdW - FracBits;
  localparam int NextW   = DeltaW + 2;
  localparam int DenW    = CovW + 1;
  localparam int RemW    = CovW + 2;
  localparam int CntW    = $clog2(GainW);

  localparam logic [GainW-1:0] GainOne = {1'b1, {FracBits{1'b0}}};

  // program counter and step addresses
  localparam int PcW = 3;
  localparam logic [PcW-1:0] StepIdle   = PcW'(0);
  localparam logic [PcW-1:0] StepPrior  = PcW'(1);
  localparam logic [PcW-1:0] StepDenom  = PcW'(2);
  localparam logic [PcW-1:0] StepDiv    = PcW'(3);
  localparam logic [PcW-1:0] StepMulG   = PcW'(4);
  localparam logic [PcW-1:0] StepEst    = PcW'(5);
  localparam logic [PcW-1:0] StepMulC   = PcW'(6);
  localparam logic [PcW-1:0] StepCov    = PcW'(7);

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_PRIOR,
    UOP_DENOM,
    UOP_DIV,
    UOP_MUL_GAIN,
    UOP_EST,
    UOP_MUL_COV,
    UOP_COV
  } uop_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_DEN_ZERO,
    JC_LOOP,
    JC_OUT_FREE,
    JC_GOTO
  } jcond_e;

  typedef struct packed {
    uop_e             op;
    jcond_e           jc;
    logic [PcW-1:0]   target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      StepIdle:  w = '{op: UOP_NOP,      jc: JC_WAIT_IN,  target: StepIdle};
      StepPrior: w = '{op: UOP_PRIOR,    jc: JC_NEXT,     target: StepIdle};
      StepDenom: w = '{op: UOP_DENOM,    jc: JC_DEN_ZERO, target: StepMulG};
      StepDiv:   w = '{op: UOP_DIV,      jc: JC_LOOP,     target: StepIdle};
      StepMulG:  w = '{op: UOP_MUL_GAIN, jc: JC_NEXT,     target: StepIdle};
      StepEst:   w = '{op: UOP_EST,      jc: JC_OUT_FREE, target: StepIdle};
      StepMulC:  w = '{op: UOP_MUL_COV,  jc: JC_NEXT,     target: StepIdle};
      StepCov:   w = '{op: UOP_COV,      jc: JC_GOTO,     target: StepIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/skf_meas_if.sv]
// skf_meas_if: measurement channel, valid/ready with one signed sample per beat
// depends on skf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface skf_meas_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MeasW-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

`default_nettype wire

[rtl/skf_est_if.sv]
// skf_est_if: estimate channel, valid/ready with one signed q16.16 estimate per beat
// depends on skf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface skf_est_if import skf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [EstW-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

`default_nettype wire

[rtl/scalar_kalman_filter.sv]
// scalar_kalman_filter: 1-d kalman filter run by a small microcode program over one datapath
// depends on skf_pkg, skf_meas_if, skf_est_if
//
//   channel   | dir | payload                         | handshake
//   meas_i    | in  | measurement, s16 integer        | valid/ready
//   est_o     | out | estimate, s32 q16.16            | valid/ready
//   cfg_*_i   | in  | idx 0 process noise, 1 meas noise | write enable only
//
// one item at a time: ready returns only once the program is back in idle after an accept.
// the restoring divider forms one gain bit per cycle, FracBits + 1 gain bits in all; a zero
// denominator skips the divider. the result is registered.
// reset loads noise defaults and clears estimate and covariance; a noise write clears both.
// a stalled result holds only the estimate step; the program waits there until the
// output register frees, and the input stays blocked until the program returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter import skf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  skf_meas_if.sink                 meas_i,
  skf_est_if.source                est_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // sequencer
  logic [PcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0] cnt_q;
  uword_t          uw;

  // architectural state
  logic [NoiseW-1:0]      pn_q, mn_q;
  logic signed [EstW-1:0] est_q;
  logic [CovW-1:0]        cov_q;

  // datapath registers
  logic signed [MeasW-1:0] meas_q;
  logic [CovW-1:0]         prior_q;
  logic [DenW-1:0]         den_q;
  logic [RemW-1:0]         rem_q;
  logic [GainW-1:0]        gain_q;
  logic [DiffW-1:0]        mag_q;
  logic                    neg_q;
  logic [ProdW-1:0]        prod_q;
  logic                    out_valid_q;
  logic signed [EstW-1:0]  out_est_q;

  // combinational
  logic                      in_fire, out_free, cfg_hit;
  logic [CovW:0]             prior_sum;
  logic [CovW-1:0]           prior_d;
  logic [DenW-1:0]           den_d;
  logic                      den_zero;
  logic signed [ScaledW-1:0] scaled;
  logic signed [DiffW-1:0]   diff;
  logic [DiffW-1:0]          mag_d;
  logic                      trial_ge;
  logic [RemW-1:0]           rem_sub, rem_next;
  logic [DiffW-1:0]          mul_a;
  logic [GainW-1:0]          mul_b;
  logic [ProdW-1:0]          prod_d;
  logic [DeltaW-1:0]         delta;
  logic signed [NextW-1:0]   est_ext, delta_s, next_est;
  logic signed [EstW-1:0]    est_sat;
  logic [CovW-1:0]           cov_d;

  assign uw = ucode_rom(pc_q);

  assign meas_i.ready = (uw.jc == JC_WAIT_IN);
  assign in_fire      = meas_i.valid && meas_i.ready;
  assign out_free     = !out_valid_q || est_o.ready;
  assign est_o.valid  = out_valid_q;
  assign est_o.estimate = out_est_q;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CfgProcessNoise || cfg_idx_i == CfgMeasNoise);

  always_comb begin
    // prior covariance, saturating
    prior_sum = {1'b0, cov_q} + {1'b0, pn_q};
    prior_d   = prior_sum[CovW] ? '1 : prior_sum[CovW-1:0];

    den_d    = {1'b0, prior_q} + {1'b0, mn_q};
    den_zero = (den_d == '0);

    // innovation as sign and magnitude
    scaled = {meas_q, {FracBits{1'b0}}};
    diff   = DiffW'(scaled) - DiffW'(est_q);
    mag_d  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

    // one restoring division step, remainder kept pre-shifted
    trial_ge = (rem_q >= RemW'(den_q));
    rem_sub  = trial_ge ? (rem_q - RemW'(den_q)) : rem_q;
    rem_next = {rem_sub[RemW-2:0], 1'b0};

    // shared multiplier
    mul_a  = (uw.op == UOP_MUL_COV) ? DiffW'(prior_q) : mag_q;
    mul_b  = (uw.op == UOP_MUL_COV) ? (GainOne - gain_q) : gain_q;
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);

    // estimate update with saturation to s32
    delta    = prod_q[ProdW-1:FracBits];
    est_ext  = NextW'(est_q);
    delta_s  = $signed({2'b00, delta});
    next_est = neg_q ? (est_ext - delta_s) : (est_ext + delta_s);
    if ((&next_est[NextW-1:EstW-1]) || !(|next_est[NextW-1:EstW-1])) begin
      est_sat = next_est[EstW-1:0];
    end else if (next_est[NextW-1]) begin
      est_sat = {1'b1, {(EstW-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(EstW-1){1'b1}}};
    end

    cov_d = (|prod_q[ProdW-1:FracBits+CovW]) ? '1 : prod_q[FracBits+CovW-1:FracBits];
  end

  // next step address
  always_comb begin
    unique case (uw.jc)
      JC_NEXT:     pc_d = pc_q + PcW'(1);
      JC_WAIT_IN:  pc_d = in_fire ? pc_q + PcW'(1) : pc_q;
      JC_DEN_ZERO: pc_d = den_zero ? uw.target : pc_q + PcW'(1);
      JC_LOOP:     pc_d = (cnt_q != '0) ? pc_q : pc_q + PcW'(1);
      JC_OUT_FREE: pc_d = out_free ? pc_q + PcW'(1) : pc_q;
      JC_GOTO:     pc_d = uw.target;
      default:     pc_d = StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pn_q        <= ProcessNoiseRst;
      mn_q        <= MeasNoiseRst;
      est_q       <= '0;
      cov_q       <= '0;
    end else begin
      pc_q <= pc_d;

      if (uw.op == UOP_DENOM) begin
        cnt_q <= CntW'(FracBits);
      end else if (uw.op == UOP_DIV && cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      if (uw.op == UOP_EST && out_free) begin
        out_valid_q <= 1'b1;
      end else if (est_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i && cfg_idx_i == CfgProcessNoise) begin
        pn_q <= cfg_data_i[NoiseW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CfgMeasNoise) begin
        mn_q <= cfg_data_i[NoiseW-1:0];
      end

      if (cfg_hit) begin
        est_q <= '0;
        cov_q <= '0;
      end else begin
        if (uw.op == UOP_EST && out_free) begin
          est_q <= est_sat;
        end
        if (uw.op == UOP_COV) begin
          cov_q <= cov_d;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      UOP_NOP: begin
        if (in_fire) begin
          meas_q <= meas_i.measurement;
        end
      end
      UOP_PRIOR: begin
        prior_q <= prior_d;
        mag_q   <= mag_d;
        neg_q   <= diff[DiffW-1];
      end
      UOP_DENOM: begin
        den_q  <= den_d;
        rem_q  <= RemW'(prior_q);
        gain_q <= '0;
      end
      UOP_DIV: begin
        rem_q  <= rem_next;
        gain_q <= {gain_q[GainW-2:0], trial_ge};
      end
      UOP_MUL_GAIN, UOP_MUL_COV: begin
        prod_q <= prod_d;
      end
      UOP_EST: begin
        if (out_free) begin
          out_est_q <= est_sat;
        end
      end
      UOP_COV: ;
      default: ;
    endcase
  end

  // the gain never passes 1.0 once the divider is done
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == UOP_MUL_GAIN) |-> (gain_q <= GainOne))
    else $error("gain above one");

  // divider remainder stays below twice the denominator
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == UOP_DIV) |-> (rem_q < {den_q, 1'b0}))
    else $error("divider remainder out of range");

  // a noise write clears the filter state
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (est_q == '0 && cov_q == '0))
    else $error("state not cleared after noise write");

  // a result beat is only loaded by the estimate step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(uw.op) == UOP_EST))
    else $error("result loaded outside estimate step");

  // posterior covariance never exceeds the prior
  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == UOP_COV && !cfg_hit) |=> (cov_q <= $past(prior_q)))
    else $error("covariance grew past prior");

endmodule

`default_nettype wire
